// ===== src/pearson_correlation_accumulator_assert.svh =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator assertion macros
// Concurrent check wrappers clocked on clk, with and without reset masking.
// ---------------------------------------------------------------------------
`ifndef PEARSON_CORRELATION_ACCUMULATOR_ASSERT_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_ASSERT_SVH

// check while out of reset
`define PCA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define PCA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pca_pkg.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator package
// Widths, accumulator snapshot type and multiplier handshake types.
// ---------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 47;
  localparam int XY_W        = 48;
  localparam int RHO_W       = 16;
  localparam int MUL_W       = 64;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int MCNT_W      = $clog2(MUL_W);
  localparam int NUM_W       = MUL_W + 2;
  localparam int QUO_W       = 31;
  localparam int ROOT_W      = 16;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SREM_W      = ROOT_W + 2;
  localparam int IN_DATA_W   = 2 * SAMPLE_W;
  localparam int OUT_DATA_W  = 40;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [SQ_W-1:0]         sxx;
    logic [SQ_W-1:0]         syy;
    logic signed [XY_W-1:0]  sxy;
    logic                    ovf;
  } acc_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

endpackage

`default_nettype wire

// ===== src/pca_front.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator front end
// Takes sample pairs, accumulates count, sums, squares and cross products.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_front import pca_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // obs_value, pred_value
  input  wire logic [1:0]           in_tuser,  // obs_valid, pred_valid
  input  wire logic                 in_tlast,  // last_pair
  input  wire fifo_sts_t            q_sts,
  output logic                      push,
  output acc_t                      push_data
);

  acc_t                       acc_r;
  acc_t                       acc_nxt;
  logic                       fire;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] y;
  logic signed [SUM_W-1:0]    xx;
  logic signed [SUM_W-1:0]    yy;
  logic signed [SUM_W-1:0]    xy;

  assign in_tready = !q_sts.full;
  assign fire      = in_tvalid && in_tready;
  assign x         = $signed(in_tdata[SAMPLE_W-1:0]);
  assign y         = $signed(in_tdata[IN_DATA_W-1:SAMPLE_W]);
  assign xx        = x * x;
  assign yy        = y * y;
  assign xy        = x * y;

  always_comb begin
    acc_nxt = acc_r;
    if (fire && in_tuser[0] && in_tuser[1]) begin
      if (acc_r.n == CNT_W'(MAX_SAMPLES)) begin
        acc_nxt.ovf = 1'b1;
      end else begin
        acc_nxt.n   = acc_r.n + CNT_W'(1);
        acc_nxt.sx  = acc_r.sx + SUM_W'(x);
        acc_nxt.sy  = acc_r.sy + SUM_W'(y);
        acc_nxt.sxx = acc_r.sxx + SQ_W'($unsigned(xx));
        acc_nxt.syy = acc_r.syy + SQ_W'($unsigned(yy));
        acc_nxt.sxy = acc_r.sxy + XY_W'(xy);
      end
    end
  end

  assign push      = fire && in_tlast;
  assign push_data = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (push) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/pca_fifo.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator snapshot queue
// Two-entry queue of accumulator snapshots between front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_fifo import pca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire acc_t push_data,
  input  wire logic pop,
  output acc_t      head,
  output fifo_sts_t sts
);

  acc_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign head      = mem_r[rd_ptr_r];
  assign sts.full  = (cnt_r == 2'd2);
  assign sts.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`include "pearson_correlation_accumulator_assert.svh"
  `PCA_CHECK(a_no_push_full, push |-> !sts.full, "push into full queue")
  `PCA_CHECK(a_no_pop_empty, pop |-> !sts.empty, "pop from empty queue")
  `PCA_CHECK_ALWAYS(a_cnt_range, !rst_n || cnt_r != 2'd3, "queue count out of range")

endmodule

`default_nettype wire

// ===== src/pca_mul.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_mul import pca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mul_req_t          req,
  output mul_sts_t               sts,
  output logic [PROD_W-1:0]      prod
);

  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  hi_r;
  logic [MUL_W-1:0]  lo_r;
  logic [MCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MUL_W:0]    sum;

  assign sum      = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      hi_r <= '0;
      lo_r <= req.b;
    end else if (busy_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + MCNT_W'(1);
        if (cnt_r == MCNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pca_back.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator back end
// Forms numerator and variances, divides and takes the root unless a variance is zero, drives result.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_back import pca_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire acc_t                  head,
  input  wire fifo_sts_t             q_sts,
  output logic                       pop,
  output mul_req_t                   mreq,
  input  wire mul_sts_t              msts,
  input  wire logic [PROD_W-1:0]     prod,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // rho, pair_count
  output logic [1:0]                 out_tuser   // zero_denominator, count_overflow
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SQRT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [2:0] M_NXY = 3'd0;
  localparam logic [2:0] M_XY  = 3'd1;
  localparam logic [2:0] M_NXX = 3'd2;
  localparam logic [2:0] M_XX  = 3'd3;
  localparam logic [2:0] M_NYY = 3'd4;
  localparam logic [2:0] M_YY  = 3'd5;
  localparam logic [2:0] M_NN  = 3'd6;
  localparam logic [2:0] M_AB  = 3'd7;

  state_t                   state_r;
  acc_t                     sn_r;
  logic [2:0]               step_r;
  logic                     issued_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [MUL_W-1:0]         va_r;
  logic [MUL_W-1:0]         vb_r;
  logic [PROD_W-1:0]        ab_r;
  logic [PROD_W:0]          rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [4:0]               it_r;
  logic [RAD_W-1:0]         rad_r;
  logic [ROOT_W-1:0]        root_r;
  logic [SREM_W-1:0]        srem_r;
  logic [RHO_W-1:0]         rho_r;
  logic                     zd_r;
  logic                     out_valid_r;

  logic [XY_W-1:0]          sxy_mag;
  logic [SUM_W-1:0]         sx_mag;
  logic [SUM_W-1:0]         sy_mag;
  logic [NUM_W-1:0]         num_abs;
  logic [MUL_W-1:0]         p64;
  logic signed [NUM_W-1:0]  pterm;
  logic [MUL_W-1:0]         vb_fin;
  logic                     div_ge;
  logic [PROD_W:0]          div_t;
  logic [QUO_W-1:0]         quo_new;
  logic [SREM_W-1:0]        rem2;
  logic [SREM_W-1:0]        trial;
  logic                     sq_ge;
  logic [ROOT_W-1:0]        root_new;

  assign sxy_mag = sn_r.sxy[XY_W-1] ? (~sn_r.sxy + XY_W'(1)) : sn_r.sxy;
  assign sx_mag  = sn_r.sx[SUM_W-1] ? (~sn_r.sx + SUM_W'(1)) : sn_r.sx;
  assign sy_mag  = sn_r.sy[SUM_W-1] ? (~sn_r.sy + SUM_W'(1)) : sn_r.sy;
  assign num_abs = num_r[NUM_W-1] ? (~num_r + NUM_W'(1)) : num_r;
  assign p64     = prod[MUL_W-1:0];
  assign pterm   = $signed({2'b00, p64});
  assign vb_fin  = vb_r - p64;

  assign div_ge  = (rem_r >= {1'b0, ab_r});
  assign div_t   = div_ge ? (rem_r - {1'b0, ab_r}) : rem_r;
  assign quo_new = {quo_r[QUO_W-2:0], div_ge};

  assign rem2     = {srem_r[SREM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial    = {root_r, 2'b01};
  assign sq_ge    = (rem2 >= trial);
  assign root_new = {root_r[ROOT_W-2:0], sq_ge};

  assign pop = (state_r == S_IDLE) && !q_sts.empty;

  always_comb begin
    mreq.start = (state_r == S_MUL) && !issued_r;
    unique case (step_r)
      M_NXY: begin
        mreq.a = MUL_W'(sn_r.n);
        mreq.b = MUL_W'(sxy_mag);
      end
      M_XY: begin
        mreq.a = MUL_W'(sx_mag);
        mreq.b = MUL_W'(sy_mag);
      end
      M_NXX: begin
        mreq.a = MUL_W'(sn_r.n);
        mreq.b = MUL_W'(sn_r.sxx);
      end
      M_XX: begin
        mreq.a = MUL_W'(sx_mag);
        mreq.b = MUL_W'(sx_mag);
      end
      M_NYY: begin
        mreq.a = MUL_W'(sn_r.n);
        mreq.b = MUL_W'(sn_r.syy);
      end
      M_YY: begin
        mreq.a = MUL_W'(sy_mag);
        mreq.b = MUL_W'(sy_mag);
      end
      M_NN: begin
        mreq.a = num_abs[MUL_W-1:0];
        mreq.b = num_abs[MUL_W-1:0];
      end
      M_AB: begin
        mreq.a = va_r;
        mreq.b = vb_r;
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sn_r <= head;
    end
    if (state_r == S_MUL && msts.done) begin
      case (step_r)
        M_NXY: num_r <= sn_r.sxy[XY_W-1] ? -pterm : pterm;
        M_XY:  num_r <= (sn_r.sx[SUM_W-1] ^ sn_r.sy[SUM_W-1]) ? num_r + pterm : num_r - pterm;
        M_NXX: va_r  <= p64;
        M_XX:  va_r  <= va_r - p64;
        M_NYY: vb_r  <= p64;
        M_YY:  vb_r  <= vb_fin;
        M_NN:  rem_r <= {1'b0, prod};
        default: ab_r <= prod;
      endcase
    end
    if (state_r == S_DIV) begin
      quo_r <= quo_new;
      rem_r <= {div_t[PROD_W-1:0], 1'b0};
      if (it_r == 5'(QUO_W - 1)) begin
        rad_r  <= RAD_W'(quo_new);
        root_r <= '0;
        srem_r <= '0;
      end
    end else if (state_r == S_MUL) begin
      quo_r <= '0;
    end
    if (state_r == S_SQRT) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      root_r <= root_new;
      srem_r <= sq_ge ? (rem2 - trial) : rem2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= M_NXY;
      issued_r    <= 1'b0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
      rho_r       <= '0;
      zd_r        <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            state_r  <= S_MUL;
            step_r   <= M_NXY;
            issued_r <= 1'b0;
          end
        end
        S_MUL: begin
          if (mreq.start) begin
            issued_r <= 1'b1;
          end
          if (msts.done) begin
            issued_r <= 1'b0;
            step_r   <= step_r + 3'd1;
            if (step_r == M_YY && (va_r == '0 || vb_fin == '0)) begin
              rho_r       <= '0;
              zd_r        <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else if (step_r == M_AB) begin
              it_r    <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          it_r <= it_r + 5'd1;
          if (it_r == 5'(QUO_W - 1)) begin
            it_r    <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          it_r <= it_r + 5'd1;
          if (it_r == 5'(ROOT_W - 1)) begin
            if (num_r[NUM_W-1]) begin
              rho_r <= ~root_new + RHO_W'(1);
            end else if (root_new[ROOT_W-1]) begin
              rho_r <= {1'b0, {(RHO_W-1){1'b1}}};
            end else begin
              rho_r <= root_new;
            end
            zd_r        <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({sn_r.n, rho_r});
  assign out_tuser  = {sn_r.ovf, zd_r};

`include "pearson_correlation_accumulator_assert.svh"
  `PCA_CHECK(a_done_in_mul, msts.done |-> (state_r == S_MUL), "multiplier done outside MUL")
  `PCA_CHECK(a_start_idle_mul, mreq.start |-> !msts.busy, "multiplier restarted while busy")
  `PCA_CHECK(a_valid_out, out_valid_r == (state_r == S_OUT), "result valid out of OUT state")

endmodule

`default_nettype wire

// ===== src/pearson_correlation_accumulator.sv =====
// ---------------------------------------------------------------------------
// Pearson correlation accumulator
// Accumulates paired samples and emits signed Q1.15 correlation per series.
// ---------------------------------------------------------------------------
// Channel  Dir  tdata                          tuser
// in_      in   obs_value, pred_value          obs_valid, pred_valid (tlast=last_pair)
// out_     out  rho, pair_count                zero_denominator, count_overflow
//
// One pair per cycle enters the accumulators while in_tready is high; a series
// ending queues a snapshot. Per series the back end takes the snapshot, runs 8
// multiplies on the shared serial multiplier (start, shift-add steps, done),
// then the divide and root steps and the result; it takes no new snapshot
// until that result is taken. A zero denominator ends after six multiplies.
// Two snapshots may wait; in_tready drops while both queue slots are full.
// Reset is synchronous, active low, and clears accumulators and queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pearson_correlation_accumulator import pca_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // obs_value, pred_value
  input  wire logic [1:0]            in_tuser,   // obs_valid, pred_valid
  input  wire logic                  in_tlast,   // last_pair
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // rho, pair_count
  output logic [1:0]                 out_tuser   // zero_denominator, count_overflow
);

  fifo_sts_t         q_sts;
  logic              push;
  acc_t              push_data;
  logic              pop;
  acc_t              head;
  mul_req_t          mreq;
  mul_sts_t          msts;
  logic [PROD_W-1:0] prod;

  pca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_sts     (q_sts),
    .push      (push),
    .push_data (push_data)
  );

  pca_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .sts       (q_sts)
  );

  pca_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .sts   (msts),
    .prod  (prod)
  );

  pca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_sts      (q_sts),
    .pop        (pop),
    .mreq       (mreq),
    .msts       (msts),
    .prod       (prod),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pearson correlation accumulator testbench
// Streams series of paired samples into the block, predicts each
// end-of-series correlation result and compares it field by field with the
// output stream. Sender idling, receiver stalls and a long receiver hold-off
// are all exercised.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pca_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] obs;
    logic signed [SAMPLE_W-1:0] pred;
    bit                         obs_ok;
    bit                         pred_ok;
    bit                         last;
  } pair_t;

  typedef struct {
    logic signed [RHO_W-1:0] rho;
    logic [CNT_W-1:0]        cnt;
    bit                      zero_den;
    bit                      ovf;
  } corr_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  pair_t pair_q[$];
  corr_t corr_q[$];
  int    idle_pct = 0;
  int    stall_pct = 0;
  bit    rx_hold = 1'b0;
  bit    hold_go = 1'b0;
  bit    failed = 1'b0;

  int unsigned n_acc = 0;
  longint      sx = 0, sy = 0, sxx = 0, syy = 0, sxy = 0;
  bit          ovf_acc = 1'b0;

  pearson_correlation_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic corr_t close_series();
    corr_t r;
    logic signed [127:0] nn, ex, ey, num, va, vb;
    logic [255:0] ab, mag, rhs, lhs;
    int unsigned lo, hi, mid;
    nn = n_acc;
    ex = sx;
    ey = sy;
    num = nn * sxy - ex * ey;
    va = nn * sxx - ex * ex;
    vb = nn * syy - ey * ey;
    r.cnt = n_acc[CNT_W-1:0];
    r.ovf = ovf_acc;
    if (va == 0 || vb == 0) begin
      r.rho = '0;
      r.zero_den = 1'b1;
    end else begin
      r.zero_den = 1'b0;
      ab = 256'(va[127:0]) * 256'(vb[127:0]);
      mag = (num < 0) ? 256'(-num) : 256'(num);
      rhs = (mag * mag) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = ab * 256'(mid * mid);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (num < 0) r.rho = RHO_W'(-int'(lo));
      else r.rho = (lo > 32767) ? 16'sd32767 : RHO_W'(lo);
    end
    return r;
  endfunction

  // accumulate every accepted pair and predict the series result
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] x, y;
    if (rst_n && in_tvalid && in_tready) begin
      x = in_tdata[SAMPLE_W-1:0];
      y = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      if (in_tuser[0] && in_tuser[1]) begin
        if (n_acc >= MAX_SAMPLES) ovf_acc = 1'b1;
        else begin
          n_acc++;
          sx += x;
          sy += y;
          sxx += longint'(x) * x;
          syy += longint'(y) * y;
          sxy += longint'(x) * y;
        end
      end
      if (in_tlast) begin
        corr_q.insert(corr_q.size(), close_series());
        n_acc = 0;
        sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        ovf_acc = 1'b0;
      end
    end
  end

  // driver: advance to the next pair after each transfer
  always @(posedge clk) begin
    pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pair_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        p = pair_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {p.pred, p.obs};
        in_tuser <= {p.pred_ok, p.obs_ok};
        in_tlast <= p.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    corr_t e;
    corr_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a.rho = out_tdata[RHO_W-1:0];
      a.cnt = out_tdata[RHO_W+CNT_W-1:RHO_W];
      a.zero_den = out_tuser[0];
      a.ovf = out_tuser[1];
      if (corr_q.size() == 0) begin
        $display("%0t: unexpected result rho=%0d count=%0d zero_den=%0b ovf=%0b",
                 $time, a.rho, a.cnt, a.zero_den, a.ovf);
        failed = 1'b1;
      end else begin
        e = corr_q.pop_front();
        if (a.rho !== e.rho) begin
          $display("%0t: rho expected %0d actual %0d", $time, e.rho, a.rho);
          failed = 1'b1;
        end
        if (a.cnt !== e.cnt) begin
          $display("%0t: pair_count expected %0d actual %0d", $time, e.cnt, a.cnt);
          failed = 1'b1;
        end
        if (a.zero_den !== e.zero_den) begin
          $display("%0t: zero_denominator expected %0b actual %0b",
                   $time, e.zero_den, a.zero_den);
          failed = 1'b1;
        end
        if (a.ovf !== e.ovf) begin
          $display("%0t: count_overflow expected %0b actual %0b", $time, e.ovf, a.ovf);
          failed = 1'b1;
        end
        if (out_tdata[OUT_DATA_W-1:RHO_W+CNT_W] !== '0) begin
          $display("%0t: tdata pad expected 0 actual %0h", $time,
                   out_tdata[OUT_DATA_W-1:RHO_W+CNT_W]);
          failed = 1'b1;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #(20ns * 6000000);
    $display("pearson_correlation_accumulator test failed");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] rnd_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_pair(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
                           bit xo, bit yo, bit l);
    pair_t p;
    p.obs = x;
    p.pred = y;
    p.obs_ok = xo;
    p.pred_ok = yo;
    p.last = l;
    pair_q.insert(pair_q.size(), p);
  endtask

  // random series: independent, correlated, anti-correlated or constant
  task automatic add_series(int len, ref int cnt);
    int kind;
    logic signed [SAMPLE_W-1:0] x, y, c;
    bit xo, yo;
    kind = $urandom_range(4);
    c = rnd_sample();
    for (int i = 0; i < len; i++) begin
      x = rnd_sample();
      case (kind)
        0, 1: y = rnd_sample();
        2: y = x + 16'($signed($urandom_range(64)) - 32);
        3: y = -x + 16'($signed($urandom_range(8)) - 4);
        default: begin
          x = c;
          y = rnd_sample();
        end
      endcase
      xo = $urandom_range(99) < 90;
      yo = $urandom_range(99) < 90;
      push_pair(x, y, xo, yo, i == len - 1);
      cnt++;
    end
  endtask

  task automatic drain();
    wait (pair_q.size() == 0);
    @(posedge clk);
    wait (!in_tvalid && corr_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic run_phase(int items);
    int cnt;
    cnt = 0;
    while (cnt < items) add_series($urandom_range(99) < 80 ? $urandom_range(1, 12)
                                                            : $urandom_range(13, 60), cnt);
  endtask

  initial begin
    int cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty series, single pair, perfect +/- correlation, extremes,
    // half-valid pairs, constant observation
    push_pair(16'sd5, 16'sd7, 1'b0, 1'b1, 1'b1);
    push_pair(16'sd5, 16'sd7, 1'b1, 1'b1, 1'b1);
    push_pair(16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b0);
    push_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    push_pair(16'sd3, 16'sd3, 1'b1, 1'b1, 1'b1);
    push_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b1, 1'b0);
    push_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b0);
    push_pair(16'sh0000, 16'shffff, 1'b1, 1'b1, 1'b1);
    push_pair(16'sd100, 16'sd1, 1'b1, 1'b0, 1'b0);
    push_pair(16'sd200, 16'sd2, 1'b1, 1'b1, 1'b0);
    push_pair(16'sd300, 16'sd9, 1'b1, 1'b1, 1'b0);
    push_pair(16'sd400, 16'sd4, 1'b0, 1'b1, 1'b1);
    push_pair(16'sd50, 16'sd1, 1'b1, 1'b1, 1'b0);
    push_pair(16'sd50, 16'sd2, 1'b1, 1'b1, 1'b1);
    push_pair(-16'sd1, 16'sd2, 1'b1, 1'b1, 1'b0);
    push_pair(16'sd1, -16'sd2, 1'b1, 1'b1, 1'b1);
    drain();

    run_phase(300);
    drain();

    idle_pct = 74;
    run_phase(250);
    drain();

    idle_pct = 0;
    stall_pct = 74;
    run_phase(250);
    drain();

    // receiver held off while short series keep arriving
    stall_pct = 0;
    hold_go = 1'b1;
    cnt = 0;
    for (int i = 0; i < 40; i++) add_series($urandom_range(1, 4), cnt);
    drain();

    idle_pct = 32;
    stall_pct = 32;
    run_phase(250);
    drain();

    idle_pct = 0;
    stall_pct = 0;
    run_phase(200);
    drain();

    repeat (1500) @(posedge clk);
    if (!failed && corr_q.size() == 0)
      $display("pearson_correlation_accumulator test passed");
    else
      $display("pearson_correlation_accumulator test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/pca_pkg.sv
src/pca_front.sv
src/pca_fifo.sv
src/pca_mul.sv
src/pca_back.sv
src/pearson_correlation_accumulator.sv
bench/tb_top.sv
